// ===== rtl/shell_line_tokenizer_defines.svh =====
`ifndef SHELL_LINE_TOKENIZER_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_DEFINES_SVH

// checked only out of reset
`define SLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SLT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_BYTE   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WEND   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PIPE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REDIR  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LEND   = 3'd5;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
	localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7c;

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_QUOTE   = 3'd2,
		MODE_QESC    = 3'd3,
		MODE_GT      = 3'd4
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] tbyte;
	} tok_t;

	typedef struct packed {
		logic last;
		tok_t tok;
	} entry_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
		mode_t      mode;
		logic       qk;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/shell_line_tokenizer.sv =====
// shell line tokenizer: lexes a command line one character per beat
// s_* channel: one character per beat in s_tdata; 0 or unquoted LF ends a line
// m_* channel: one token per beat; tuser carries the kind, tdata the word
//   byte, tlast marks the final token caused by one input character
// a character gives zero, one or two tokens (word end + line end, etc.)
// path: a character taken is held in the input register, lexed there, and
//   its tokens are written into the queue, whose count drives m_tvalid
// throughput: one character per cycle while the queue has room; the input register is drained into
//   a four-entry token queue whenever the queue has room for two tokens,
//   so the queue's drain rate of one token per cycle is the only limit
// when the receiver stalls the queue fills, the input register holds its
//   character and s_tready drops; no token is lost or repeated
// reset clears the lexer to between tokens with single-quote kind, and
//   empties the input register and the queue
`default_nettype none

module shell_line_tokenizer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [slt_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_in
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [slt_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] token_byte
	output logic [slt_pkg::KIND_W-1:0]      m_tuser,   // [2:0] token_kind
	output logic                            m_tlast    // last
);
	import slt_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	mode_t             mode_q;
	logic              qk_q;

	entry_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	logic              proc;
	logic              pop;
	res_t              res;
	entry_t            e0;
	entry_t            e1;
	logic [1:0]        push_n;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_quote(input logic [CHAR_W-1:0] c);
		return (c == CH_SQUOTE) || (c == CH_DQUOTE);
	endfunction

	function automatic res_t f_emit(input logic [KIND_W-1:0] kind,
			input logic [CHAR_W-1:0] tb, input mode_t mode, input logic qk);
		res_t r;
		r = '0;
		r.n = 2'd1;
		r.t0.kind = kind;
		r.t0.tbyte = tb;
		r.mode = mode;
		r.qk = qk;
		return r;
	endfunction

	function automatic res_t f_between(input logic [CHAR_W-1:0] c, input logic qk);
		res_t r;
		r = '0;
		r.mode = MODE_BETWEEN;
		r.qk = qk;
		if (c == CH_NUL || c == CH_LF) begin
			r = f_emit(KIND_LEND, CH_NUL, MODE_BETWEEN, qk);
		end else if (is_blank(c)) begin
			r.mode = MODE_BETWEEN;
		end else if (c == CH_PIPE) begin
			r = f_emit(KIND_PIPE, CH_NUL, MODE_BETWEEN, qk);
		end else if (c == CH_GT) begin
			r.mode = MODE_GT;
		end else if (is_quote(c)) begin
			r.mode = MODE_QUOTE;
			r.qk = (c == CH_DQUOTE);
		end else begin
			r = f_emit(KIND_BYTE, c, MODE_WORD, qk);
		end
		return r;
	endfunction

	function automatic res_t f_quote(input logic [CHAR_W-1:0] c, input logic qk);
		res_t r;
		logic [CHAR_W-1:0] closer;
		closer = qk ? CH_DQUOTE : CH_SQUOTE;
		r = '0;
		r.mode = MODE_QUOTE;
		r.qk = qk;
		if (c == CH_NUL) begin
			// open quote cut short: close the word and the line
			r.n = 2'd2;
			r.t0.kind = KIND_WEND;
			r.t1.kind = KIND_LEND;
			r.mode = MODE_BETWEEN;
		end else if (c == closer) begin
			r.mode = MODE_WORD;
		end else if (c == CH_BSLASH) begin
			r.mode = MODE_QESC;
		end else begin
			r = f_emit(KIND_BYTE, c, MODE_QUOTE, qk);
		end
		return r;
	endfunction

	// put one token ahead of a result that has at most one
	function automatic res_t f_prepend(input logic [KIND_W-1:0] kind,
			input logic [CHAR_W-1:0] tb, input res_t r);
		res_t o;
		o = r;
		o.n = r.n + 2'd1;
		o.t0.kind = kind;
		o.t0.tbyte = tb;
		o.t1 = r.t0;
		return o;
	endfunction

	always_comb begin
		case (mode_q)
			MODE_WORD: begin
				if (char_s1 == CH_NUL || char_s1 == CH_LF || is_blank(char_s1) ||
						char_s1 == CH_PIPE || char_s1 == CH_GT) begin
					res = f_prepend(KIND_WEND, CH_NUL, f_between(char_s1, qk_q));
				end else if (is_quote(char_s1)) begin
					res = '0;
					res.mode = MODE_QUOTE;
					res.qk = (char_s1 == CH_DQUOTE);
				end else begin
					res = f_emit(KIND_BYTE, char_s1, MODE_WORD, qk_q);
				end
			end
			MODE_QUOTE: begin
				res = f_quote(char_s1, qk_q);
			end
			MODE_QESC: begin
				if (is_quote(char_s1)) begin
					res = f_emit(KIND_BYTE, char_s1, MODE_QUOTE, qk_q);
				end else if (char_s1 == CH_NUL) begin
					res = f_quote(char_s1, qk_q);
				end else begin
					// backslash kept, then the character as in a quote
					res = f_prepend(KIND_BYTE, CH_BSLASH, f_quote(char_s1, qk_q));
				end
			end
			MODE_GT: begin
				if (char_s1 == CH_GT) begin
					res = f_emit(KIND_APPEND, CH_NUL, MODE_BETWEEN, qk_q);
				end else begin
					res = f_prepend(KIND_REDIR, CH_NUL, f_between(char_s1, qk_q));
				end
			end
			default: begin
				res = f_between(char_s1, qk_q);
			end
		endcase
	end

	// lex only when the queue can take two tokens
	assign proc     = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || proc;
	assign pop      = m_tvalid && m_tready;
	assign push_n   = proc ? res.n : 2'd0;

	always_comb begin
		e0.last = (res.n == 2'd1);
		e0.tok  = res.t0;
		e1.last = 1'b1;
		e1.tok  = res.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_BETWEEN;
			qk_q     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (proc) begin
				mode_q <= res.mode;
				qk_q   <= res.qk;
			end
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= e0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= e1;
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = mem_q[rd_ptr_q].tok.tbyte;
	assign m_tuser  = mem_q[rd_ptr_q].tok.kind;
	assign m_tlast  = mem_q[rd_ptr_q].last;

endmodule

`default_nettype wire

// ===== rtl/slt_checker.sv =====
`default_nettype none
`include "shell_line_tokenizer_defines.svh"

module slt_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [slt_pkg::CHAR_W-1:0] m_tdata,
	input wire logic [slt_pkg::KIND_W-1:0] m_tuser,
	input wire logic                       m_tlast
);
	import slt_pkg::*;

	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] tbyte;

	assign kind  = m_tuser;
	assign tbyte = m_tdata;

	`SLT_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !m_tvalid, "token beat during reset")
	`SLT_ASSERT(a_lend_last, m_tvalid && kind == KIND_LEND |-> m_tlast, "line end not last")
	`SLT_ASSERT(a_byte_zero, m_tvalid && kind != KIND_BYTE |-> tbyte == CH_NUL, "stray byte")
	`SLT_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "beat withdrawn")
	`SLT_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "beat changed")

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (.*);

`default_nettype wire
